FILE: hw/rtl/crc16_frame_append_check_assert.svh
// ---------------------------------------------------------------------------
// CRC-16 frame append/check assertion macros
// Assertion wrappers shared by the core and queue RTL files of the block.
// ---------------------------------------------------------------------------
`ifndef CRC16_FRAME_APPEND_CHECK_ASSERT_SVH
`define CRC16_FRAME_APPEND_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF
// Generic form: explicit clock and active-low reset.
`define CRCFA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Short form on the block's own clock and reset.
`define CRCFA_ASSERT(lbl, prop, msg) \
    `CRCFA_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define CRCFA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CRCFA_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/crcfa_pkg.sv
// ---------------------------------------------------------------------------
// CRC-16 frame append/check package
// Shared constants, result types and the CRC byte update function.
// ---------------------------------------------------------------------------
package crcfa_pkg;

    localparam logic [15:0] CrcInit   = 16'hFFFF;
    localparam logic [15:0] CrcPoly   = 16'h8005;
    localparam logic [15:0] CrcTopBit = 16'h8000;

    // Most results one byte can cause (append mode, frame end).
    localparam int MaxResults = 3;
    // Result queue depth and the fill level up to which a byte is taken.
    localparam int QueueDepth = 8;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);
    localparam int FillLimit  = QueueDepth - MaxResults;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       crc_ok;
        logic       run_last;
    } t_result;

    // Results produced by one accepted byte, oldest in entry 0.
    typedef struct packed {
        logic [1:0]                     count;
        t_result [MaxResults-1:0]       res;
    } t_push;

    // One byte through the CRC, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CrcTopBit) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic t_result mk_result(input logic [7:0] b, input logic status,
                                          input logic ok, input logic last);
        t_result r;
        r.out_byte  = b;
        r.is_status = status;
        r.crc_ok    = ok;
        r.run_last  = last;
        return r;
    endfunction

endpackage

FILE: hw/rtl/crcfa_core.sv
// ---------------------------------------------------------------------------
// CRC-16 frame append/check core
// Holds back the last two bytes, runs the CRC and forms the results of a byte.
// ---------------------------------------------------------------------------
`include "crc16_frame_append_check_assert.svh"

module crcfa_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_frame_end,
    output crcfa_pkg::t_push    o_push
);

    logic [15:0] r_crc, n_crc;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_h0, n_h0;
    logic [7:0]  r_h1, n_h1;
    logic        r_check_mode;
    logic [15:0] crc_next;
    logic        crc_match;
    crcfa_pkg::t_push push;

    assign crc_next  = crcfa_pkg::crc_feed(r_crc, r_h0);
    assign crc_match = (r_h1 == crc_next[15:8]) && (i_data_byte == crc_next[7:0]);

    always_comb begin
        n_crc = r_crc;
        n_cnt = r_cnt;
        n_h0  = r_h0;
        n_h1  = r_h1;
        push  = '0;
        if (i_accept) begin
            if (r_cnt == 2'd2) begin
                n_crc = crc_next;
                n_h0  = r_h1;
                n_h1  = i_data_byte;
                if (r_check_mode) begin
                    if (i_frame_end) begin
                        push.res[0] = crcfa_pkg::mk_result(8'h00, 1'b1, crc_match, 1'b1);
                        push.count  = 2'd1;
                    end
                end else begin
                    push.res[0] = crcfa_pkg::mk_result(r_h0, 1'b0, 1'b0, 1'b0);
                    push.count  = 2'd1;
                    if (i_frame_end) begin
                        push.res[1] = crcfa_pkg::mk_result(crc_next[15:8], 1'b0, 1'b0, 1'b0);
                        push.res[2] = crcfa_pkg::mk_result(crc_next[7:0], 1'b0, 1'b0, 1'b1);
                        push.count  = 2'd3;
                    end
                end
            end else begin
                if (r_cnt[0]) begin
                    n_h1 = i_data_byte;
                end else begin
                    n_h0 = i_data_byte;
                end
                n_cnt = r_cnt + 2'd1;
                if (i_frame_end) begin
                    // Short frame: passes unchanged, or fails the check.
                    if (r_check_mode) begin
                        push.res[0] = crcfa_pkg::mk_result(8'h00, 1'b1, 1'b0, 1'b1);
                        push.count  = 2'd1;
                    end else if (r_cnt == 2'd0) begin
                        push.res[0] = crcfa_pkg::mk_result(i_data_byte, 1'b0, 1'b0, 1'b1);
                        push.count  = 2'd1;
                    end else begin
                        push.res[0] = crcfa_pkg::mk_result(r_h0, 1'b0, 1'b0, 1'b0);
                        push.res[1] = crcfa_pkg::mk_result(i_data_byte, 1'b0, 1'b0, 1'b1);
                        push.count  = 2'd2;
                    end
                end
            end
            if (i_frame_end) begin
                n_crc = crcfa_pkg::CrcInit;
                n_cnt = 2'd0;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= crcfa_pkg::CrcInit;
            r_cnt        <= 2'd0;
            r_check_mode <= 1'b0;
        end else begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                r_check_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h0 <= n_h0;
        r_h1 <= n_h1;
    end

    `CRCFA_ASSERT(a_cnt_range, r_cnt != 2'd3, "held byte count out of range")
    `CRCFA_ASSERT(a_frame_restart, i_accept && i_frame_end |=> r_cnt == 2'd0 && r_crc == crcfa_pkg::CrcInit, "frame end did not restart the CRC")
    `CRCFA_ASSERT(a_check_quiet, i_accept && !i_frame_end && r_check_mode |-> push.count == 2'd0, "check mode produced a result mid-frame")

endmodule

FILE: hw/rtl/crcfa_queue.sv
// ---------------------------------------------------------------------------
// CRC-16 frame append/check result queue
// Takes up to three results a cycle and hands them out one a cycle while the reader pops.
// ---------------------------------------------------------------------------
`include "crc16_frame_append_check_assert.svh"

module crcfa_queue (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  crcfa_pkg::t_push                        i_push,
    input  logic                                    i_pop,
    output logic                                    o_valid,
    output logic                                    o_room,
    output crcfa_pkg::t_result                      o_result
);

    crcfa_pkg::t_result r_mem [crcfa_pkg::QueueDepth];
    logic [crcfa_pkg::QueuePtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [crcfa_pkg::QueuePtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [crcfa_pkg::QueueCntW-1:0] r_count, n_count;
    logic                            pop;

    assign pop      = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + crcfa_pkg::QueuePtrW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + crcfa_pkg::QueuePtrW'(pop);
    assign n_count  = r_count + crcfa_pkg::QueueCntW'(i_push.count)
                              - crcfa_pkg::QueueCntW'(pop);

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < crcfa_pkg::QueueDepth; j++) begin
            logic [crcfa_pkg::QueuePtrW-1:0] off;
            off = crcfa_pkg::QueuePtrW'(j) - r_wr_ptr;
            if (off < crcfa_pkg::QueuePtrW'(i_push.count)) begin
                r_mem[j] <= i_push.res[off[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= crcfa_pkg::QueueCntW'(crcfa_pkg::FillLimit));
    assign o_result = r_mem[r_rd_ptr];

    `CRCFA_ASSERT(a_no_overflow, (i_push.count != 2'd0) |-> o_room, "results pushed without room")
    `CRCFA_ASSERT(a_count_track, $past(i_rst_n) && !$past(pop) && $past(i_push.count) == 2'd0 |-> $stable(r_count), "queue count moved without a push or pop")

endmodule

FILE: hw/rtl/crc16_frame_append_check.sv
// ---------------------------------------------------------------------------
// CRC-16 frame append/check
// Streams frames byte by byte; appends or verifies a CRC-16/CMS trailer.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Request moves                      | Handshake
//  --------+-----------+------------------------------------+----------------------------
//  s_axis  | in        | one frame byte, tlast on last byte | s_axis_tvalid/s_axis_tready
//  m_axis  | out       | one byte or one check verdict      | m_axis_tvalid/m_axis_tready
//  cfg     | in        | check_mode register write          | i_cfg_valid/o_cfg_ready
//
// One input byte is taken per cycle while the queue has room. The CRC byte
// update, the hold-back of the last two bytes and the forming of the results
// sit between the input handshake and an eight-entry result queue. A frame
// end in append mode gives up to three results, which the queue drains one per
// cycle while m_axis_tready is high and new bytes keep coming in; the input
// stalls only when more than five results are waiting, i.e. the output stalls.
// Reset (synchronous, active low) empties the queue, restarts the CRC at 0xFFFF
// and sets append mode. Configuration writes are always taken.
// ---------------------------------------------------------------------------
module crc16_frame_append_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: bit 0 is check_mode (0 append, 1 check).
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // Byte input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // frame_end
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [0] is_status, [1] crc_ok
    output logic        m_axis_tlast    // run_last
);

    logic               in_accept;
    logic               room;
    crcfa_pkg::t_push   push;
    crcfa_pkg::t_result head;

    // The queue always keeps room for the largest burst one byte can cause,
    // so the ready does not depend on the byte or the mode.
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;
    assign o_cfg_ready   = 1'b1;

    crcfa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_data_byte (s_axis_tdata),
        .i_frame_end (s_axis_tlast),
        .o_push      (push)
    );

    crcfa_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_room   (room),
        .o_result (head)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = {head.crc_ok, head.is_status};
    assign m_axis_tlast = head.run_last;

endmodule

FILE: dv/tb_crc16_frame_append_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the CRC-16 frame append/check block
// Sends frames in append and check mode. Each result is compared with the
// output of a CRC-16/CMS predictor kept alongside the block.
// ---------------------------------------------------------------------------
//
// The stimulus runs as a list of test tasks. They share one task that sends a
// frame byte and one that writes the mode register. A single clocked process
// samples every handshake. It feeds each accepted byte request into the
// predictor and compares each accepted result request with the oldest expected
// result. Both stream sides idle at random, apart from stretches in which one
// side or the other runs flat out.
// ---------------------------------------------------------------------------
module tb_crc16_frame_append_check;

    // Mode register values.
    localparam logic ModeAppend = 1'b0;
    localparam logic ModeCheck  = 1'b1;

    // CRC-16/CMS: MSB first, no reflection, no final XOR.
    localparam logic [15:0] CrcSeed       = 16'hFFFF;
    localparam logic [15:0] CrcPolynomial = 16'h8005;

    // Random byte requests after the directed tests.
    localparam int RandomBytes   = 480;
    // Results are registered in the result queue before they leave. This margin
    // covers any pipelining that the block's own description does not mention.
    localparam int SettleCycles  = 4;
    localparam int TailCycles    = 16;
    // The longest correct run without any handshake is one long stall on
    // either side plus a settle. This limit leaves a wide margin over that.
    localparam int WatchdogLimit = 2000;

    typedef logic [7:0] frame_bytes_t[$];

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data    = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;   // frame_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0] m_axis_tuser;           // [0] is_status, [1] crc_ok
    logic       m_axis_tlast;           // run_last

    crc16_frame_append_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state. It is written only by the clocked process below.
    logic [15:0] run_crc  = CrcSeed;
    logic [7:0]  hold_buf [2];
    logic [1:0]  hold_cnt = 2'd0;
    logic        check_en = ModeAppend;

    // Results that the block still owes, oldest first.
    crcfa_pkg::t_result pending_results[$];

    int error_count  = 0;
    int sent_bytes   = 0;
    int quiet_cycles = 0;
    int sink_wait    = 0;
    logic src_steady  = 1'b0;
    logic sink_steady = 1'b0;
    // The mode as the stimulus side last wrote it.
    logic cur_mode    = ModeAppend;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CrcPolynomial) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic status,
                                         input logic ok, input logic last);
        crcfa_pkg::t_result r;
        r.out_byte  = b;
        r.is_status = status;
        r.crc_ok    = ok;
        r.run_last  = last;
        pending_results.push_back(r);
    endfunction

    // Works out the results of one accepted byte. The last two bytes of a
    // frame are always held back: only the byte that falls out of the hold
    // buffer enters the CRC (and, in append mode, goes out).
    function automatic void predict_frame_byte(input logic [7:0] b, input logic last);
        logic [7:0] released;
        logic       match;
        if (hold_cnt >= 2'd2) begin
            released = hold_buf[0];
            run_crc  = crc_next(run_crc, released);
            if (check_en == ModeAppend) begin
                queue_result(released, 1'b0, 1'b0, 1'b0);
            end
            hold_buf[0] = hold_buf[1];
            hold_buf[1] = b;
            if (last) begin
                if (check_en == ModeCheck) begin
                    match = (hold_buf[0] == run_crc[15:8]) && (hold_buf[1] == run_crc[7:0]);
                    queue_result(8'h00, 1'b1, match, 1'b1);
                end else begin
                    queue_result(run_crc[15:8], 1'b0, 1'b0, 1'b0);
                    queue_result(run_crc[7:0], 1'b0, 1'b0, 1'b1);
                end
            end
        end else begin
            hold_buf[hold_cnt[0]] = b;
            hold_cnt = hold_cnt + 2'd1;
            if (last) begin
                // A frame too short to carry a CRC passes as it is, or fails
                // the check.
                if (check_en == ModeCheck) begin
                    queue_result(8'h00, 1'b1, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < int'(hold_cnt); i++) begin
                        queue_result(hold_buf[i], 1'b0, 1'b0, (i + 1) == int'(hold_cnt));
                    end
                end
            end
        end
        // Every frame end restarts the CRC and empties the hold buffer.
        if (last) begin
            run_crc  = CrcSeed;
            hold_cnt = 2'd0;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, expected, got);
        error_count++;
    endtask

    // All handshakes are sampled at the rising edge, before the block's and
    // the stimulus' nonblocking updates land. A byte is predicted before any
    // result of the same edge is checked, so a result could even come out
    // combinationally.
    always @(posedge i_clk) begin
        crcfa_pkg::t_result want;
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                check_en = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_frame_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result (out_byte)", 0, int'(m_axis_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.out_byte) begin
                        report_mismatch("out_byte", int'(want.out_byte),
                                        int'(m_axis_tdata));
                    end
                    if (m_axis_tuser[0] !== want.is_status) begin
                        report_mismatch("is_status", int'(want.is_status),
                                        int'(m_axis_tuser[0]));
                    end
                    if (m_axis_tuser[1] !== want.crc_ok) begin
                        report_mismatch("crc_ok", int'(want.crc_ok), int'(m_axis_tuser[1]));
                    end
                    if (m_axis_tlast !== want.run_last) begin
                        report_mismatch("run_last", int'(want.run_last), int'(m_axis_tlast));
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Idling
    // -----------------------------------------------------------------------

    // Most gaps are empty, some are short and a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // The receiver drops ready for a random stall, or keeps it high while
    // sink_steady is set.
    always @(posedge i_clk) begin
        if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
        end else if (!sink_steady) begin
            sink_wait = pick_gap();
        end
        m_axis_tready <= (sink_wait == 0);
    end

    // -----------------------------------------------------------------------
    // Shared stimulus tasks
    // -----------------------------------------------------------------------

    // Sends one byte request. It returns at the edge that accepts the request,
    // with valid still high, so the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    // Lets the block run dry: no byte request is offered, every expected
    // result has come, and the pipeline has had time to empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // The mode is only written while the block is idle, which may be in the
    // middle of a frame: the held bytes are state, not work in flight.
    task automatic write_mode(input logic mode);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    // Sends a whole frame. When switch_at is a byte index, the mode flips
    // just before that byte.
    task automatic send_frame(input frame_bytes_t bytes, input int switch_at);
        for (int i = 0; i < bytes.size(); i++) begin
            if (i == switch_at) begin
                write_mode(~cur_mode);
            end
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Payload followed by its CRC, high byte first.
    function automatic frame_bytes_t with_crc(input frame_bytes_t payload);
        logic [15:0] crc;
        frame_bytes_t f;
        crc = CrcSeed;
        f   = payload;
        foreach (payload[i]) begin
            crc = crc_next(crc, payload[i]);
        end
        f.push_back(crc[15:8]);
        f.push_back(crc[7:0]);
        return f;
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Frames of one and two bytes carry no CRC: they pass unchanged when
    // appending and fail when checking.
    task automatic test_short_frames();
        write_mode(ModeAppend);
        send_frame('{8'h00}, -1);
        send_frame('{8'hFF, 8'h80}, -1);
        write_mode(ModeCheck);
        send_frame('{8'h7F}, -1);
        send_frame('{8'h01, 8'hFE}, -1);
    endtask

    // The extreme byte values through the CRC in append mode.
    task automatic test_byte_extremes();
        write_mode(ModeAppend);
        send_frame('{8'h00, 8'hFF, 8'h01, 8'h80}, -1);
    endtask

    // One frame with a correct trailer and one with its low CRC bit flipped.
    task automatic test_check_verdicts();
        frame_bytes_t f;
        write_mode(ModeCheck);
        send_frame(with_crc('{8'hFF, 8'h00}), -1);
        f = with_crc('{8'h5A});
        f[2] = f[2] ^ 8'h01;
        send_frame(f, -1);
    endtask

    // The mode flips in the middle of a frame, both ways. Bytes released
    // before the flip stay in the CRC.
    task automatic test_mode_switch_in_frame();
        write_mode(ModeAppend);
        send_frame('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, 3);
        send_frame('{8'hA0, 8'hB0, 8'hC0, 8'hD0}, 3);
    endtask

    // Random frames. Lengths are mostly short, sometimes too short for a CRC
    // and now and then long. In check mode most frames carry a good trailer,
    // so that both verdicts come up often.
    task automatic test_random_frames();
        frame_bytes_t f;
        int last_count;
        int len;
        int pick;
        int switch_at;
        last_count = sent_bytes + RandomBytes;
        while (sent_bytes < last_count) begin
            src_steady  = ($urandom_range(0, 99) < 15);
            sink_steady = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 15) begin
                write_mode(1'($urandom_range(0, 1)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                len = $urandom_range(1, 2);
            end else if (pick < 92) begin
                len = $urandom_range(3, 12);
            end else begin
                len = $urandom_range(20, 64);
            end
            f.delete();
            if (cur_mode == ModeCheck && len >= 3 && $urandom_range(0, 99) < 75) begin
                for (int i = 0; i < len - 2; i++) begin
                    f.push_back(8'($urandom_range(0, 255)));
                end
                f = with_crc(f);
                // A single flipped bit anywhere must spoil the verdict.
                if ($urandom_range(0, 3) == 0) begin
                    pick = $urandom_range(0, len - 1);
                    f[pick] = f[pick] ^ (8'h01 << $urandom_range(0, 7));
                end
            end else begin
                for (int i = 0; i < len; i++) begin
                    f.push_back(8'($urandom_range(0, 255)));
                end
            end
            switch_at = ($urandom_range(0, 99) < 6) ? $urandom_range(1, len - 1) : -1;
            if (len < 2) begin
                switch_at = -1;
            end
            send_frame(f, switch_at);
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_frames();
        test_byte_extremes();
        test_check_verdicts();
        test_mode_switch_in_frame();
        test_random_frames();
        settle();
        repeat (TailCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[crc16_frame_append_check] OK");
        end else begin
            $display("[crc16_frame_append_check] ERROR");
        end
        $finish;
    end

    // A run that stops moving has hung: no request passed on any channel for
    // far longer than any correct run idles.
    initial begin
        while (quiet_cycles < WatchdogLimit) @(posedge i_clk);
        $display("[crc16_frame_append_check] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/crcfa_pkg.sv
hw/rtl/crcfa_core.sv
hw/rtl/crcfa_queue.sv
hw/rtl/crc16_frame_append_check.sv
dv/tb_crc16_frame_append_check.sv
